// ----- sv/tcpq_pkg.sv -----
// Shared types and constants for the two-class priority queue.
// No dependencies; used by every module of the block.
`default_nettype none

package tcpq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int OP_W      = 2;
    localparam int ID_W      = 16;
    localparam int ENTRY_W   = ID_W + 1;   // {is_peak, bus_id}
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 24;         // bus_id, is_peak, zero fill
    localparam int M_TDATA_W = 24;         // out_bus_id, out_express, out_peak, zero fill

    // Operation codes (s_tuser)
    localparam logic [OP_W-1:0] OP_ENQ_REGULAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ_EXPRESS = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPATCH    = 2'd2;

    // Result status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } store_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } store_stat_t;

endpackage

`default_nettype wire

// ----- sv/tcpq_class_store.sv -----
// One class of the queue: circular entry memory with head, tail and count.
// Depends on tcpq_pkg. Read data is registered: it appears in the cycle after the pop.
`default_nettype none

module tcpq_class_store #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  tcpq_pkg::store_ctrl_t ctrl,
    input  tcpq_pkg::entry_t      wr_entry,
    output tcpq_pkg::entry_t      rd_entry,
    output tcpq_pkg::store_stat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tcpq_pkg::entry_t mem [DEPTH];
    tcpq_pkg::entry_t rd_entry_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_FULL);
    assign rd_entry   = rd_entry_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push) begin
            tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry memory: one write port at tail, one registered read port at head
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg] <= wr_entry;
        end
        if (ctrl.pop) begin
            rd_entry_reg <= mem[head_reg];
        end
    end

endmodule

`default_nettype wire

// ----- sv/two_class_priority_queue_top.sv -----
// Two-class strict-priority queue: top level with op decode and result register.
// Depends on tcpq_pkg and tcpq_class_store.
//
// Usage:
//   Slave channel (s_*): one beat per operation. s_tuser carries the op code
//   (enqueue regular, enqueue express, dispatch; code 3 acts as dispatch),
//   s_tdata carries the entry to enqueue.
//   Master channel (m_*): exactly one result beat per operation, in order.
//   m_tuser is the status (enqueued, dispatched, empty, class full),
//   m_tdata the dispatched entry or zero.
// Result path:
//   Enqueues and dispatches on an empty queue: the result is registered and
//   shows in the cycle after the beat; the next beat can be taken as it drains.
//   Dispatch with data: the entry memory read is registered, so the result
//   goes via the read state to the result register; no beat is taken meanwhile.
// Reset: aresetn low clears both classes (head, tail, count), the state and the
//   result valid and holds s_tready low; result data, tuser and memory contents
//   are not cleared and need no sweep.
// Stall: the result register holds while m_tready is low; s_tready drops
//   until the pending result is taken, so nothing is lost or repeated.
`default_nettype none

module two_class_priority_queue_top #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // slave: tdata = {zero fill, is_peak[16], bus_id[15:0]}
    input  wire [tcpq_pkg::S_TDATA_W-1:0]      s_tdata,
    // slave: tuser = op[1:0]
    input  wire [tcpq_pkg::OP_W-1:0]           s_tuser,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // master: tdata = {zero fill, out_peak[17], out_express[16], out_bus_id[15:0]}
    output logic [tcpq_pkg::M_TDATA_W-1:0]     m_tdata,
    // master: tuser = status[1:0]
    output logic [tcpq_pkg::STATUS_W-1:0]      m_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready
);

    localparam logic ST_IDLE = 1'b0;   // ready for a beat
    localparam logic ST_READ = 1'b1;   // waiting on memory read data

    logic state_reg, state_next;
    logic sel_express_reg, sel_express_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [tcpq_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [tcpq_pkg::STATUS_W-1:0]     m_tuser_reg, m_tuser_next;

    tcpq_pkg::store_ctrl_t exp_ctrl, reg_ctrl;
    tcpq_pkg::store_stat_t exp_stat, reg_stat;
    tcpq_pkg::entry_t      exp_rd, reg_rd, wr_entry, rd_sel;

    logic in_beat;

    assign wr_entry = s_tdata[tcpq_pkg::ENTRY_W-1:0];

    // Only one item in flight; result register frees as it drains
    assign s_tready = aresetn && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_beat  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rd_sel = sel_express_reg ? exp_rd : reg_rd;

    tcpq_class_store #(.DEPTH(DEPTH)) u_express (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (exp_ctrl),
        .wr_entry (wr_entry),
        .rd_entry (exp_rd),
        .stat     (exp_stat)
    );

    tcpq_class_store #(.DEPTH(DEPTH)) u_regular (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (reg_ctrl),
        .wr_entry (wr_entry),
        .rd_entry (reg_rd),
        .stat     (reg_stat)
    );

    always_comb begin
        exp_ctrl         = '0;
        reg_ctrl         = '0;
        state_next       = state_reg;
        sel_express_next = sel_express_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        if (state_reg == ST_READ) begin
            // Output register is known free here: it drained at the accept edge
            m_tvalid_next = 1'b1;
            m_tuser_next  = tcpq_pkg::ST_DISPATCHED;
            m_tdata_next  = '0;
            m_tdata_next[tcpq_pkg::ID_W-1:0] = rd_sel[tcpq_pkg::ID_W-1:0];
            m_tdata_next[tcpq_pkg::ID_W]     = sel_express_reg;
            m_tdata_next[tcpq_pkg::ID_W+1]   = rd_sel[tcpq_pkg::ID_W];
            state_next    = ST_IDLE;
        end else if (in_beat) begin
            m_tdata_next = '0;
            case (s_tuser)
                tcpq_pkg::OP_ENQ_REGULAR: begin
                    m_tvalid_next = 1'b1;
                    reg_ctrl.push = !reg_stat.full;
                    m_tuser_next  = reg_stat.full ? tcpq_pkg::ST_FULL
                                                  : tcpq_pkg::ST_ENQUEUED;
                end
                tcpq_pkg::OP_ENQ_EXPRESS: begin
                    m_tvalid_next = 1'b1;
                    exp_ctrl.push = !exp_stat.full;
                    m_tuser_next  = exp_stat.full ? tcpq_pkg::ST_FULL
                                                  : tcpq_pkg::ST_ENQUEUED;
                end
                default: begin
                    // dispatch (unused code 3 included): express first
                    if (!exp_stat.empty) begin
                        exp_ctrl.pop     = 1'b1;
                        sel_express_next = 1'b1;
                        state_next       = ST_READ;
                    end else if (!reg_stat.empty) begin
                        reg_ctrl.pop     = 1'b1;
                        sel_express_next = 1'b0;
                        state_next       = ST_READ;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = tcpq_pkg::ST_EMPTY;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_express_reg <= sel_express_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

endmodule

`default_nettype wire

// ----- sv/tcpq_checker.sv -----
// Port-level checks for the two-class priority queue, bound to the top level.
// Depends on tcpq_pkg and two_class_priority_queue_top.
`default_nettype none

module tcpq_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire [tcpq_pkg::M_TDATA_W-1:0]      m_tdata,
    input wire [tcpq_pkg::STATUS_W-1:0]       m_tuser,
    input wire                                m_tvalid,
    input wire                                m_tready
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the result channel
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // After a beat, either a result shows or the input stays blocked
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("new beat taken before previous result");

    // Non-dispatch results carry all-zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != tcpq_pkg::ST_DISPATCHED) |-> m_tdata == '0)
        else $error("nonzero data on non-dispatch result");

endmodule

bind two_class_priority_queue_top tcpq_checker u_tcpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
